/* rtl/iff_pkg.sv */
// ----------------------------------------------------------------------------
// iff_pkg
// Shared types, constants and helpers of the integer field formatter.
// ----------------------------------------------------------------------------
package iff_pkg;

   // field and digit sizing
   localparam int MAX_FIELD   = 64;
   localparam int DIGIT_SLOTS = 22;
   localparam int BIN_W       = 64;
   localparam int K_W         = $clog2(MAX_FIELD);
   localparam int DIG_IDX_W   = $clog2(DIGIT_SLOTS);
   localparam int CNT_W       = $clog2(BIN_W);
   localparam int ND_W        = $clog2(DIGIT_SLOTS + 1);
   localparam int POS_W       = 8;

   // radix codes
   localparam logic [1:0] RADIX_OCT = 2'd0;
   localparam logic [1:0] RADIX_DEC = 2'd1;
   localparam logic [1:0] RADIX_HEX = 2'd2;
   localparam logic [1:0] RADIX_BAD = 2'd3;

   // flag bit positions
   localparam int FLAG_ZEROPAD = 0;
   localparam int FLAG_SIGNED  = 1;
   localparam int FLAG_PLUS    = 2;
   localparam int FLAG_SPACE   = 3;
   localparam int FLAG_LEFT    = 4;
   localparam int FLAG_LOWER   = 5;
   localparam int FLAG_PREFIX  = 6;

   // characters
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_UPX   = 8'h58;
   localparam logic [7:0] CH_CASE  = 8'h20;
   localparam logic [7:0] CH_NUL   = 8'h00;

   // controller to datapath commands
   typedef struct packed {
      logic load;
      logic conv_step;
      logic size;
      logic plan;
      logic layout;
      logic advance;
      logic fault;
   } cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic last;
   } stat_type;

   // one digit value to its ascii character
   function automatic logic [7:0] digit_char(input logic [3:0] d, input logic lower);
      logic [7:0] ch;
      if (d < 4'd10) begin
         ch = CH_ZERO + {4'h0, d};
      end else begin
         ch = (8'h37 + {4'h0, d}) | (lower ? CH_CASE : 8'h00);
      end
      return ch;
   endfunction

endpackage

/* rtl/integer_field_formatter.sv */
// ----------------------------------------------------------------------------
// integer_field_formatter
// Sequence: decimal runs the conversion loop and then the size, plan and
//   layout states; octal and hex skip the loop; a bad radix goes straight to its fault answer.
// Throughput: one character per cycle while rsp_ready is high; the next input
//   word is taken the cycle after the last character; decimal conversion is a
//   64-step shift-and-adjust loop, one binary bit per cycle.
// Reset: synchronous active-high reset returns the controller to idle.
// ----------------------------------------------------------------------------
module integer_field_formatter (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [63:0] req_value,
   input  logic [1:0]  req_radix_code,
   input  logic [6:0]  req_field_width,
   input  logic [5:0]  req_min_digits,
   input  logic [6:0]  req_format_flags,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_out_char,
   output logic        rsp_last,
   output logic        rsp_bad_radix
);
   import iff_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   // sequencing
   iff_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_radix_code (req_radix_code),
      .rsp_ready      (rsp_ready),
      .stat           (stat),
      .req_ready      (req_ready),
      .rsp_valid      (rsp_valid),
      .cmd            (cmd)
   );

   // conversion and character generation
   iff_datapath u_datapath (
      .clock            (clock),
      .cmd              (cmd),
      .req_value        (req_value),
      .req_radix_code   (req_radix_code),
      .req_field_width  (req_field_width),
      .req_min_digits   (req_min_digits),
      .req_format_flags (req_format_flags),
      .stat             (stat),
      .rsp_out_char     (rsp_out_char),
      .rsp_last         (rsp_last),
      .rsp_bad_radix    (rsp_bad_radix)
   );

endmodule

/* rtl/iff_ctrl.sv */
// ----------------------------------------------------------------------------
// iff_ctrl
// Controller of the integer field formatter: sequences capture, binary to
// decimal conversion, field layout and the character stream.
// ----------------------------------------------------------------------------
module iff_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic [1:0]        req_radix_code,
   input  logic              rsp_ready,
   input  iff_pkg::stat_type stat,
   output logic              req_ready,
   output logic              rsp_valid,
   output iff_pkg::cmd_type  cmd
);
   import iff_pkg::*;

   typedef enum logic [6:0] {
      ST_IDLE   = 7'b0000001,
      ST_CONV   = 7'b0000010,
      ST_SIZE   = 7'b0000100,
      ST_PLAN   = 7'b0001000,
      ST_LAYOUT = 7'b0010000,
      ST_EMIT   = 7'b0100000,
      ST_FAULT  = 7'b1000000
   } state_type;

   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               req_take;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = (state_ff == ST_EMIT) || (state_ff == ST_FAULT);
   assign req_take  = req_valid && req_ready;

   // next state and commands
   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      cmd           = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               cmd.load = 1'b1;
               cnt_in   = '0;
               if (req_radix_code == RADIX_BAD) begin
                  state_in = ST_FAULT;
               end else if (req_radix_code == RADIX_DEC) begin
                  state_in = ST_CONV;
               end else begin
                  state_in = ST_SIZE;
               end
            end
         end
         ST_CONV: begin
            cmd.conv_step = 1'b1;
            cnt_in        = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(BIN_W - 1)) begin
               state_in = ST_SIZE;
            end
         end
         ST_SIZE: begin
            cmd.size = 1'b1;
            state_in = ST_PLAN;
         end
         ST_PLAN: begin
            cmd.plan = 1'b1;
            state_in = ST_LAYOUT;
         end
         ST_LAYOUT: begin
            cmd.layout = 1'b1;
            state_in   = ST_EMIT;
         end
         ST_EMIT: begin
            if (rsp_ready) begin
               if (stat.last) begin
                  state_in = ST_IDLE;
               end else begin
                  cmd.advance = 1'b1;
               end
            end
         end
         ST_FAULT: begin
            cmd.fault = 1'b1;
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

`ifndef ASSERT_OFF
   // never take a new word while a result word is offered
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("input taken while output pending");

   // bad radix answers in the very next cycle
   a_fault_next: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_radix_code == RADIX_BAD) |=> rsp_valid)
      else $error("bad radix not answered");

   // conversion runs exactly one step per binary bit
   a_conv_len: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CONV && cnt_ff == CNT_W'(BIN_W - 1)) |=> (state_ff == ST_SIZE))
      else $error("conversion length wrong");

   // the final word of a field frees the input side
   a_last_free: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && stat.last) |=> req_ready)
      else $error("not idle after last word");
`endif

endmodule

/* rtl/iff_datapath.sv */
// ----------------------------------------------------------------------------
// iff_datapath
// Datapath of the integer field formatter: magnitude capture, serial binary
// to bcd conversion, digit count, field layout and character selection.
// ----------------------------------------------------------------------------
module iff_datapath (
   input  logic              clock,
   input  iff_pkg::cmd_type  cmd,
   input  logic [63:0]       req_value,
   input  logic [1:0]        req_radix_code,
   input  logic [6:0]        req_field_width,
   input  logic [5:0]        req_min_digits,
   input  logic [6:0]        req_format_flags,
   output iff_pkg::stat_type stat,
   output logic [7:0]        rsp_out_char,
   output logic              rsp_last,
   output logic              rsp_bad_radix
);
   import iff_pkg::*;

   typedef logic [DIGIT_SLOTS-1:0][3:0] dig_type;

   // captured item
   dig_type              dig_ff, dig_in;
   logic [BIN_W-1:0]     bin_ff, bin_in;
   logic [6:0]           width_ff, width_in;
   logic [5:0]           prec_ff, prec_in;
   logic                 zp_ff, zp_in;
   logic                 left_ff, left_in;
   logic                 lower_ff, lower_in;
   logic                 sgn_ff, sgn_in;
   logic [7:0]           sign_ch_ff, sign_ch_in;
   logic [1:0]           pfx_ff, pfx_in;
   // layout
   logic [ND_W-1:0]      nd_ff, nd_in;
   logic [6:0]           pad_ff, pad_in;
   logic [5:0]           pe_ff, pe_in;
   logic [POS_W-1:0]     b1_ff, b2_ff, b3_ff, b5_ff, b6_ff;
   logic [POS_W-1:0]     b1_in, b2_in, b3_in, b4_in, b5_in, b6_in;
   logic [K_W-1:0]       last_idx_ff, last_idx_in;
   logic [K_W-1:0]       k_ff, k_in;

   logic [BIN_W-1:0]                 mag;
   logic                             neg;
   logic [DIGIT_SLOTS*3-1:0]         oct_ext;
   logic [DIGIT_SLOTS*4-1:0]         hex_ext;
   dig_type                          oct_dig, adj;
   logic [DIGIT_SLOTS*4-1:0]         adj_flat;
   logic [8:0]                       wid_t;
   logic [5:0]                       pe_c;
   logic [POS_W-1:0]                 pad8, tot, tot_m1;
   logic [POS_W-1:0]                 kk, didx_full;
   logic [DIG_IDX_W-1:0]             didx;
   logic [3:0]                       dsel;
   logic [7:0]                       ch;

   // sign handling and digit extraction at capture
   always_comb begin
      neg     = req_format_flags[FLAG_SIGNED] & req_value[BIN_W-1];
      mag     = neg ? (BIN_W'(0) - req_value) : req_value;
      oct_ext = {(DIGIT_SLOTS*3-BIN_W)'(0), mag};
      hex_ext = {(DIGIT_SLOTS*4-BIN_W)'(0), mag};
      for (int i = 0; i < DIGIT_SLOTS; i++) begin
         oct_dig[i] = {1'b0, oct_ext[3*i +: 3]};
      end
   end

   // double dabble adjust of every bcd digit
   always_comb begin
      for (int i = 0; i < DIGIT_SLOTS; i++) begin
         adj[i] = (dig_ff[i] >= 4'd5) ? (dig_ff[i] + 4'd3) : dig_ff[i];
      end
      adj_flat = adj;
   end

   // digit count, at least one
   always_comb begin
      nd_in = nd_ff;
      if (cmd.size) begin
         nd_in = ND_W'(1);
         for (int i = 0; i < DIGIT_SLOTS; i++) begin
            if (dig_ff[i] != 4'h0) begin
               nd_in = ND_W'(i + 1);
            end
         end
      end
   end

   // effective precision and padding
   always_comb begin
      wid_t = {2'b00, width_ff} - {8'h00, sgn_ff} - {7'h00, pfx_ff};
      pe_c  = (prec_ff > {1'b0, nd_ff}) ? prec_ff : {1'b0, nd_ff};
      pe_in = cmd.plan ? pe_c : pe_ff;
      pad_in = pad_ff;
      if (cmd.plan) begin
         if (!wid_t[8] && (wid_t[7:0] > {2'b00, pe_c})) begin
            pad_in = 7'(wid_t[7:0] - {2'b00, pe_c});
         end else begin
            pad_in = '0;
         end
      end
   end

   // segment boundaries of the field
   always_comb begin
      pad8   = {1'b0, pad_ff};
      b1_in  = (!zp_ff && !left_ff) ? pad8 : '0;
      b2_in  = b1_in + {7'h00, sgn_ff};
      b3_in  = b2_in + {6'h00, pfx_ff};
      b4_in  = b3_in + (zp_ff ? pad8 : '0);
      b5_in  = b4_in + {2'b00, pe_ff} - {3'b000, nd_ff};
      b6_in  = b5_in + {3'b000, nd_ff};
      tot    = b6_in + (left_ff ? pad8 : '0);
      tot_m1 = tot - 8'd1;
      last_idx_in = (tot > POS_W'(MAX_FIELD)) ? K_W'(MAX_FIELD - 1) : tot_m1[K_W-1:0];
   end

   // capture, conversion and counter next values
   always_comb begin
      dig_in     = dig_ff;
      bin_in     = bin_ff;
      width_in   = width_ff;
      prec_in    = prec_ff;
      zp_in      = zp_ff;
      left_in    = left_ff;
      lower_in   = lower_ff;
      sgn_in     = sgn_ff;
      sign_ch_in = sign_ch_ff;
      pfx_in     = pfx_ff;
      k_in       = k_ff;
      if (cmd.load) begin
         bin_in   = mag;
         width_in = req_field_width;
         prec_in  = req_min_digits;
         left_in  = req_format_flags[FLAG_LEFT];
         zp_in    = req_format_flags[FLAG_ZEROPAD] & ~req_format_flags[FLAG_LEFT];
         lower_in = req_format_flags[FLAG_LOWER];
         sgn_in   = req_format_flags[FLAG_SIGNED] &
                    (req_value[BIN_W-1] | req_format_flags[FLAG_PLUS] |
                     req_format_flags[FLAG_SPACE]);
         sign_ch_in = neg ? CH_MINUS :
                      (req_format_flags[FLAG_PLUS] ? CH_PLUS : CH_SPACE);
         pfx_in = 2'd0;
         if (req_format_flags[FLAG_PREFIX]) begin
            if (req_radix_code == RADIX_HEX) begin
               pfx_in = 2'd2;
            end else if (req_radix_code == RADIX_OCT) begin
               pfx_in = 2'd1;
            end
         end
         if (req_radix_code == RADIX_HEX) begin
            dig_in = hex_ext;
         end else if (req_radix_code == RADIX_OCT) begin
            dig_in = oct_dig;
         end else begin
            dig_in = '0;
         end
         k_in = '0;
      end else if (cmd.conv_step) begin
         dig_in = {adj_flat[DIGIT_SLOTS*4-2:0], bin_ff[BIN_W-1]};
         bin_in = {bin_ff[BIN_W-2:0], 1'b0};
      end else if (cmd.advance) begin
         k_in = k_ff + 1'b1;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      dig_ff     <= dig_in;
      bin_ff     <= bin_in;
      width_ff   <= width_in;
      prec_ff    <= prec_in;
      zp_ff      <= zp_in;
      left_ff    <= left_in;
      lower_ff   <= lower_in;
      sgn_ff     <= sgn_in;
      sign_ch_ff <= sign_ch_in;
      pfx_ff     <= pfx_in;
      nd_ff      <= nd_in;
      pad_ff     <= pad_in;
      pe_ff      <= pe_in;
      k_ff       <= k_in;
      if (cmd.layout) begin
         b1_ff       <= b1_in;
         b2_ff       <= b2_in;
         b3_ff       <= b3_in;
         b5_ff       <= b5_in;
         b6_ff       <= b6_in;
         last_idx_ff <= last_idx_in;
      end
   end

   // character at the current position
   always_comb begin
      kk        = {(POS_W-K_W)'(0), k_ff};
      didx_full = b6_ff - 8'd1 - kk;
      didx      = didx_full[DIG_IDX_W-1:0];
      dsel      = (didx < DIG_IDX_W'(DIGIT_SLOTS)) ? dig_ff[didx] : 4'h0;
      if (kk < b1_ff) begin
         ch = CH_SPACE;
      end else if (kk < b2_ff) begin
         ch = sign_ch_ff;
      end else if (kk < b3_ff) begin
         ch = (kk == b2_ff) ? CH_ZERO : (CH_UPX | (lower_ff ? CH_CASE : 8'h00));
      end else if (kk < b5_ff) begin
         ch = CH_ZERO;
      end else if (kk < b6_ff) begin
         ch = digit_char(dsel, lower_ff);
      end else begin
         ch = CH_SPACE;
      end
   end

   // result word
   assign rsp_out_char  = cmd.fault ? CH_NUL : ch;
   assign rsp_last      = cmd.fault | (k_ff == last_idx_ff);
   assign rsp_bad_radix = cmd.fault;
   assign stat.last     = rsp_last;

endmodule

/* tb/integer_field_formatter_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// integer_field_formatter_tb
// Drives formatting requests into the integer field formatter and checks every
// character that comes back against typed-in text or a formatter in the bench.
// A short directed table covers the radixes, the sign and prefix flags,
// padding, justification, the most negative value, overlong fields and the
// bad radix code. Random requests follow, with random gaps and stalls on both
// sides, one long receiver hold-off and two pauses that drain the block.
// ----------------------------------------------------------------------------
module integer_field_formatter_tb;
   import iff_pkg::*;

   localparam int RANDOM_WORDS = 354;
   localparam int HOLD_CYCLES  = 400;
   localparam int DRAIN_CYCLES = 100;
   localparam int CYCLE_LIMIT  = 600000;

   // flag masks built from the package bit positions
   localparam logic [6:0] F_ZEROPAD = 7'(1 << FLAG_ZEROPAD);
   localparam logic [6:0] F_SIGNED  = 7'(1 << FLAG_SIGNED);
   localparam logic [6:0] F_PLUS    = 7'(1 << FLAG_PLUS);
   localparam logic [6:0] F_SPACE   = 7'(1 << FLAG_SPACE);
   localparam logic [6:0] F_LEFT    = 7'(1 << FLAG_LEFT);
   localparam logic [6:0] F_LOWER   = 7'(1 << FLAG_LOWER);
   localparam logic [6:0] F_PREFIX  = 7'(1 << FLAG_PREFIX);
   localparam logic [6:0] F_ALL     = 7'h7F;

   localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] MOST_NEG = 64'h8000_0000_0000_0000;
   localparam logic [63:0] MOST_POS = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [7:0]  CH_UPA   = 8'h41;

   typedef struct packed {
      logic [63:0] value;
      logic [1:0]  radix;
      logic [6:0]  width;
      logic [5:0]  digits;
      logic [6:0]  flags;
   } fmt_word_type;

   typedef struct packed {
      logic [7:0] ch;
      logic       last;
      logic       fault;
   } char_word_type;

   logic        clock;
   logic        reset            = 1'b1;
   logic        req_valid        = 1'b0;
   logic        req_ready;
   logic [63:0] req_value        = '0;
   logic [1:0]  req_radix_code   = RADIX_DEC;
   logic [6:0]  req_field_width  = '0;
   logic [5:0]  req_min_digits   = '0;
   logic [6:0]  req_format_flags = '0;
   logic        rsp_valid;
   logic        rsp_ready        = 1'b0;
   logic [7:0]  rsp_out_char;
   logic        rsp_last;
   logic        rsp_bad_radix;

   // characters still owed by the block, oldest first
   char_word_type pending_chars[$];

   // directed table
   fmt_word_type  table_words[$];
   string         table_text[$];
   bit            table_fault[$];

   int          error_count   = 0;
   int          words_sent    = 0;
   int          chars_checked = 0;
   int          faults_seen   = 0;
   int          cycle_count   = 0;
   int          hold_count    = 0;
   logic        hold_off_req  = 1'b0;
   logic        hold_done     = 1'b0;
   logic        steady        = 1'b0;

   integer_field_formatter dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_value        (req_value),
      .req_radix_code   (req_radix_code),
      .req_field_width  (req_field_width),
      .req_min_digits   (req_min_digits),
      .req_format_flags (req_format_flags),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_out_char     (rsp_out_char),
      .rsp_last         (rsp_last),
      .rsp_bad_radix    (rsp_bad_radix)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // run length guard
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   initial begin : watchdog
      wait (cycle_count >= CYCLE_LIMIT);
      $display("integer_field_formatter_tb NOT OK");
      $finish;
   end

   // printf-style integer conversion, queues the characters of one field
   function automatic void format_field(input fmt_word_type w);
      logic [63:0] mag;
      logic [6:0]  fl;
      logic        lower;
      logic        has_sign;
      logic [7:0]  sign_ch;
      logic [7:0]  digits[$];
      logic [7:0]  field[$];
      logic [3:0]  d;
      logic [7:0]  ch;
      int unsigned base;
      int          span;
      int          prec;
      int          pad;
      int          k;
      int          emit;
      if (w.radix == RADIX_BAD) begin
         pending_chars.push_back('{ch: CH_NUL, last: 1'b1, fault: 1'b1});
         return;
      end
      base = (w.radix == RADIX_OCT) ? 8 : (w.radix == RADIX_DEC) ? 10 : 16;
      fl = w.flags;
      lower = fl[FLAG_LOWER];
      // left justification wins over zero padding
      if (fl[FLAG_LEFT]) fl[FLAG_ZEROPAD] = 1'b0;
      mag = w.value;
      span = int'(w.width);
      prec = int'(w.digits);
      has_sign = 1'b0;
      sign_ch = CH_NUL;
      if (fl[FLAG_SIGNED]) begin
         if (mag[63]) begin
            has_sign = 1'b1;
            sign_ch = CH_MINUS;
            mag = -mag;
         end else if (fl[FLAG_PLUS]) begin
            has_sign = 1'b1;
            sign_ch = CH_PLUS;
         end else if (fl[FLAG_SPACE]) begin
            has_sign = 1'b1;
            sign_ch = CH_SPACE;
         end
      end
      if (has_sign) span = span - 1;
      if (fl[FLAG_PREFIX]) begin
         if (base == 16) span = span - 2;
         else if (base == 8) span = span - 1;
      end
      // digits, least significant first
      do begin
         d = 4'(mag % base);
         ch = (d < 4'd10) ? CH_ZERO + 8'(d) : CH_UPA + 8'(d) - 8'd10;
         if (lower) ch = ch | CH_CASE;
         digits.push_back(ch);
         mag = mag / base;
      end while (mag != 0);
      if (digits.size() > prec) prec = digits.size();
      pad = span - prec;
      if (pad < 0) pad = 0;
      // assemble the field in print order
      if (!fl[FLAG_ZEROPAD] && !fl[FLAG_LEFT]) repeat (pad) field.push_back(CH_SPACE);
      if (has_sign) field.push_back(sign_ch);
      if (fl[FLAG_PREFIX] && base != 10) begin
         field.push_back(CH_ZERO);
         if (base == 16) field.push_back(CH_UPX | (lower ? CH_CASE : 8'h00));
      end
      if (fl[FLAG_ZEROPAD]) repeat (pad) field.push_back(CH_ZERO);
      repeat (prec - digits.size()) field.push_back(CH_ZERO);
      for (k = digits.size() - 1; k >= 0; k--) field.push_back(digits[k]);
      if (fl[FLAG_LEFT]) repeat (pad) field.push_back(CH_SPACE);
      // overlong fields are cut at the field limit
      emit = (field.size() > MAX_FIELD) ? MAX_FIELD : field.size();
      for (k = 0; k < emit; k++) begin
         pending_chars.push_back('{ch: field[k], last: (k == emit - 1), fault: 1'b0});
      end
   endfunction

   // typed-in field text
   function automatic void queue_text(input string text);
      int k;
      for (k = 0; k < text.len(); k++) begin
         pending_chars.push_back('{ch: text[k], last: (k == text.len() - 1), fault: 1'b0});
      end
   endfunction

   function automatic void add_row(input logic [63:0] value, input logic [1:0] radix,
                                   input logic [6:0] width, input logic [5:0] digits,
                                   input logic [6:0] flags, input string text,
                                   input bit fault);
      table_words.push_back('{value: value, radix: radix, width: width,
                              digits: digits, flags: flags});
      table_text.push_back(text);
      table_fault.push_back(fault);
   endfunction

   // empty text on a row that is not a fault means the row is checked against the formatter above
   function automatic void build_table();
      add_row(64'd0,      RADIX_DEC, 7'd0,   6'd0,  7'd0, "0", 0);
      add_row(ALL_ONES,   RADIX_DEC, 7'd0,   6'd0,  7'd0, "18446744073709551615", 0);
      add_row(ALL_ONES,   RADIX_HEX, 7'd0,   6'd0,  7'd0, "FFFFFFFFFFFFFFFF", 0);
      add_row(ALL_ONES,   RADIX_OCT, 7'd0,   6'd0,  7'd0, "1777777777777777777777", 0);
      add_row(MOST_NEG,   RADIX_DEC, 7'd0,   6'd0,  F_SIGNED, "-9223372036854775808", 0);
      add_row(MOST_NEG,   RADIX_HEX, 7'd0,   6'd0,  F_SIGNED | F_LOWER | F_PREFIX,
              "-0x8000000000000000", 0);
      add_row(ALL_ONES,   RADIX_DEC, 7'd0,   6'd0,  F_SIGNED, "-1", 0);
      add_row(MOST_POS,   RADIX_DEC, 7'd0,   6'd0,  F_SIGNED | F_PLUS,
              "+9223372036854775807", 0);
      add_row(64'd0,      RADIX_BAD, 7'd0,   6'd0,  7'd0, "", 1);
      add_row(ALL_ONES,   RADIX_BAD, 7'd127, 6'd63, F_ALL, "", 1);
      add_row(64'd0,      RADIX_OCT, 7'd0,   6'd0,  F_PREFIX, "00", 0);
      add_row(64'd0,      RADIX_HEX, 7'd0,   6'd0,  F_PREFIX, "0X0", 0);
      add_row(64'd255,    RADIX_HEX, 7'd0,   6'd0,  F_LOWER, "ff", 0);
      add_row(64'd42,     RADIX_DEC, 7'd0,   6'd0,  F_PREFIX, "42", 0);
      add_row(64'd42,     RADIX_DEC, 7'd0,   6'd0,  F_SIGNED | F_SPACE, " 42", 0);
      add_row(64'd42,     RADIX_DEC, 7'd0,   6'd0,  F_SIGNED | F_PLUS | F_SPACE, "+42", 0);
      add_row(64'd42,     RADIX_DEC, 7'd0,   6'd0,  F_PLUS, "42", 0);
      add_row(64'd42,     RADIX_DEC, 7'd6,   6'd0,  7'd0, "    42", 0);
      add_row(64'd42,     RADIX_DEC, 7'd6,   6'd0,  F_ZEROPAD | F_LEFT, "42    ", 0);
      add_row(64'd42,     RADIX_DEC, 7'd6,   6'd4,  F_ZEROPAD, "000042", 0);
      add_row(-64'd5,     RADIX_DEC, 7'd6,   6'd0,  F_SIGNED | F_ZEROPAD, "-00005", 0);
      add_row(64'h1F,     RADIX_HEX, 7'd10,  6'd0,  F_LOWER | F_PREFIX | F_ZEROPAD,
              "0x0000001f", 0);
      add_row(64'd0,      RADIX_DEC, 7'd64,  6'd0,  7'd0, "", 0);
      add_row(ALL_ONES,   RADIX_OCT, 7'd127, 6'd63, F_ALL, "", 0);
      add_row(64'd12345,  RADIX_OCT, 7'd127, 6'd0,  F_LEFT | F_PREFIX, "", 0);
      add_row(MOST_NEG,   RADIX_DEC, 7'd0,   6'd63, F_SIGNED | F_ZEROPAD, "", 0);
   endfunction

   // random request, mostly small fields with the odd extreme
   function automatic fmt_word_type random_word();
      fmt_word_type w;
      int unsigned pick;
      pick = $urandom_range(0, 9);
      if (pick < 3) w.value = 64'($urandom_range(0, 1000));
      else if (pick == 3) w.value = -64'($urandom_range(1, 1000));
      else if (pick == 4) begin
         case ($urandom_range(0, 3))
            0: w.value = 64'd0;
            1: w.value = ALL_ONES;
            2: w.value = MOST_NEG;
            default: w.value = MOST_POS;
         endcase
      end else w.value = {$urandom, $urandom};
      w.radix = ($urandom_range(0, 99) < 6) ? RADIX_BAD : 2'($urandom_range(0, 2));
      pick = $urandom_range(0, 9);
      if (pick < 7) w.width = 7'($urandom_range(0, 24));
      else if (pick < 9) w.width = 7'($urandom_range(0, 64));
      else w.width = 7'($urandom_range(0, 127));
      pick = $urandom_range(0, 19);
      if (pick < 12) w.digits = 6'd0;
      else if (pick < 17) w.digits = 6'($urandom_range(1, 24));
      else w.digits = 6'($urandom_range(0, 63));
      w.flags = 7'($urandom_range(0, 127));
      return w;
   endfunction

   // one request word, held until the block takes it
   task automatic send_word(input fmt_word_type w);
      req_valid        <= 1'b1;
      req_value        <= w.value;
      req_radix_code   <= w.radix;
      req_field_width  <= w.width;
      req_min_digits   <= w.digits;
      req_format_flags <= w.flags;
      do @(posedge clock); while (!req_ready);
      words_sent++;
   endtask

   task automatic maybe_idle();
      if (!steady && $urandom_range(0, 99) < 19) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   // stop sending until every owed character is back
   task automatic drain_block();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_chars.size() != 0);
   endtask

   // receiver: random stalls, one long hold-off, a stall-free stretch
   always @(posedge clock) begin
      if (hold_count > 0) begin
         hold_count <= hold_count - 1;
         rsp_ready <= 1'b0;
      end else if (hold_off_req && !hold_done) begin
         hold_done <= 1'b1;
         hold_count <= HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else if (steady) begin
         rsp_ready <= 1'b1;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= 19);
      end
   end

   // compare each accepted character with the oldest one owed
   always @(posedge clock) begin : check_chars
      char_word_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_chars.size() == 0) begin
            $error("unexpected word: out_char %h last %b bad_radix %b",
                   rsp_out_char, rsp_last, rsp_bad_radix);
            error_count++;
         end else begin
            want = pending_chars.pop_front();
            chars_checked++;
            if (want.fault) faults_seen++;
            if (rsp_out_char !== want.ch) begin
               $error("out_char mismatch: expected %h, got %h", want.ch, rsp_out_char);
               error_count++;
            end
            if (rsp_last !== want.last) begin
               $error("last mismatch: expected %b, got %b", want.last, rsp_last);
               error_count++;
            end
            if (rsp_bad_radix !== want.fault) begin
               $error("bad_radix mismatch: expected %b, got %b", want.fault, rsp_bad_radix);
               error_count++;
            end
         end
      end
   end

   initial begin : stimulus
      fmt_word_type w;
      int n;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      build_table();

      // directed table
      for (n = 0; n < table_words.size(); n++) begin
         maybe_idle();
         send_word(table_words[n]);
         if (table_fault[n]) pending_chars.push_back('{ch: CH_NUL, last: 1'b1, fault: 1'b1});
         else if (table_text[n] != "") queue_text(table_text[n]);
         else format_field(table_words[n]);
      end
      drain_block();

      // random requests
      for (n = 0; n < RANDOM_WORDS; n++) begin
         if (n == 40) hold_off_req <= 1'b1;
         if (n == 120) steady <= 1'b1;
         if (n == 200) steady <= 1'b0;
         if (n == 260) drain_block();
         maybe_idle();
         w = random_word();
         send_word(w);
         format_field(w);
      end
      drain_block();
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (pending_chars.size() != 0) begin
         $error("%0d characters never arrived", pending_chars.size());
         error_count++;
      end
      $display("%0d request words (%0d from the directed table), %0d characters checked",
               words_sent, table_words.size(), chars_checked);
      $display("%0d bad radix answers, %0d mismatches", faults_seen, error_count);
      if (error_count == 0) begin
         $display("integer_field_formatter_tb OK");
      end else begin
         $display("integer_field_formatter_tb NOT OK");
      end
      $finish;
   end

endmodule

/* filelist.f */
rtl/iff_pkg.sv
rtl/iff_ctrl.sv
rtl/iff_datapath.sv
rtl/integer_field_formatter.sv
tb/integer_field_formatter_tb.sv
